// ----- hw/rtl/mns_pkg.sv -----
// ----------------------------------------------------------------------------
// mns_pkg
// Shared widths, function codes and helpers for the melody note sequencer.
// ----------------------------------------------------------------------------
package mns_pkg;

   localparam int NOTE_DEPTH_DEF = 512;

   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 9;
   localparam int FREQ_W   = 16;
   localparam int DUR_W    = 16;
   localparam int PWM_W    = 10;
   localparam int COUNT_W  = 10;
   localparam int LEN_W    = 17;
   localparam int ADJ_W    = 14;
   localparam int DIV_W    = 20;
   localparam int DIV_STEPS = 20;
   localparam int STEP_W   = 5;
   localparam int APB_AW   = 3;
   localparam int APB_DW   = 32;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TONE  = 3'd4;

   localparam logic [DIV_W-1:0]  TONE_CLOCK   = 20'd1000000;
   localparam logic [ADJ_W-1:0]  TONE_MIN     = 14'd1200;
   localparam logic [ADJ_W-1:0]  TONE_MAX     = 14'd10000;
   localparam logic [FREQ_W-1:0] TONE_LOW     = 16'd1000;
   localparam logic [PWM_W-1:0]  RELOAD_RESET = 10'd1000;
   localparam logic [ADJ_W-1:0]  LEN_DIVISOR  = 14'd3;

   // pitch scaled by 4 or 5, clamped to the pwm range
   function automatic logic [ADJ_W-1:0] tone_adjust(input logic [FREQ_W-1:0] f);
      logic [FREQ_W+2:0] x4;
      logic [FREQ_W+2:0] adj;
      logic [ADJ_W-1:0]  res;
      x4 = {1'b0, f, 2'b00};
      adj = (f < TONE_LOW) ? x4 : x4 + {3'b000, f};
      if (adj > {5'd0, TONE_MAX}) begin
         res = TONE_MAX;
      end else if (adj < {5'd0, TONE_MIN}) begin
         res = TONE_MIN;
      end else begin
         res = adj[ADJ_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/mns_req_if.sv -----
// ----------------------------------------------------------------------------
// mns_req_if
// Request channel: command word with note and tone fields.
// ----------------------------------------------------------------------------
interface mns_req_if;
   logic                          valid;
   logic                          ready;
   logic [mns_pkg::FUNC_W-1:0]    func;
   logic [mns_pkg::INDEX_W-1:0]   note_index;
   logic [mns_pkg::FREQ_W-1:0]    note_frequency;
   logic [mns_pkg::DUR_W-1:0]     note_duration;
   logic [mns_pkg::FREQ_W-1:0]    tone_frequency;

   modport source (
      output valid, func, note_index, note_frequency, note_duration, tone_frequency,
      input  ready
   );
   modport sink (
      input  valid, func, note_index, note_frequency, note_duration, tone_frequency,
      output ready
   );
endinterface

// ----- hw/rtl/mns_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mns_rsp_if
// Response channel: pwm settings and playback status.
// ----------------------------------------------------------------------------
interface mns_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mns_pkg::PWM_W-1:0]     period_reload;
   logic [mns_pkg::PWM_W-1:0]     compare_value;
   logic                          registers_updated;
   logic                          melody_playing;
   logic [mns_pkg::INDEX_W-1:0]   note_position;

   modport source (
      output valid, period_reload, compare_value, registers_updated, melody_playing,
             note_position,
      input  ready
   );
   modport sink (
      input  valid, period_reload, compare_value, registers_updated, melody_playing,
             note_position,
      output ready
   );
endinterface

// ----- hw/rtl/melody_note_sequencer_pwm.sv -----
// ----------------------------------------------------------------------------
// melody_note_sequencer_pwm
// Note store and playback sequencer with a bit-serial divider for pwm reload and note length.
//
//   port     dir   handshake            word
//   req_if   in    valid/ready          func, note index/frequency/duration, tone
//   rsp_if   out   valid/ready          reload, compare, updated, playing, position
//   apb      in    psel/penable/pwrite  note_count @0, loop_enable @4
//
// every division runs through the one-bit-per-cycle restoring divider, and a
// tick that ends a note may divide twice. start, stop and idle ticks skip the
// divider. synchronous reset, no clearing pass. a new request is taken while
// the previous response waits in the output register.
// ----------------------------------------------------------------------------
module melody_note_sequencer_pwm #(
   parameter int NOTE_DEPTH = mns_pkg::NOTE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   mns_req_if.sink                    req_if,
   mns_rsp_if.source                  rsp_if,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mns_pkg::APB_AW-1:0] paddr,
   input  logic [mns_pkg::APB_DW-1:0] pwdata,
   output logic [mns_pkg::APB_DW-1:0] prdata,
   output logic                       pready
);

   localparam int AW  = $clog2(NOTE_DEPTH);
   localparam int CW  = mns_pkg::COUNT_W;
   localparam int XW  = (AW > CW) ? AW : CW;
   localparam int RW  = mns_pkg::FREQ_W + mns_pkg::LEN_W;
   localparam logic [XW:0] DEPTH_X = (XW+1)'(NOTE_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_NOTE = 7'b0000010,
      ST_STEP = 7'b0000100,
      ST_NEXT = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_DONE = 7'b0100000,
      ST_RESP = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic                           playing_ff, playing_in;
   logic [CW-1:0]                  cur_ff, cur_in;
   logic [mns_pkg::LEN_W-1:0]      timer_ff, timer_in;
   logic [mns_pkg::PWM_W-1:0]      reload_ff, reload_in;
   logic [mns_pkg::PWM_W-1:0]      compare_ff, compare_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic                           loop_ff, loop_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           upd_ff, upd_in;
   logic                           ret_step_ff, ret_step_in;
   logic                           div_len_ff, div_len_in;
   logic [mns_pkg::FREQ_W-1:0]     hold_pitch_ff, hold_pitch_in;
   logic [AW-1:0]                  hold_addr_ff, hold_addr_in;
   logic [mns_pkg::DIV_W-1:0]      div_q_ff, div_q_in;
   logic [mns_pkg::ADJ_W-1:0]      div_rem_ff, div_rem_in;
   logic [mns_pkg::ADJ_W-1:0]      div_d_ff, div_d_in;
   logic [mns_pkg::STEP_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [mns_pkg::PWM_W-1:0]      out_reload_ff, out_compare_ff;
   logic                           out_upd_ff, out_playing_ff;
   logic [mns_pkg::INDEX_W-1:0]    out_pos_ff;
   logic                           out_load;

   logic                           div_start;
   logic [mns_pkg::DIV_W-1:0]      div_dividend;
   logic [mns_pkg::ADJ_W-1:0]      div_divisor;
   logic [mns_pkg::ADJ_W:0]        trial;
   logic                           trial_ge;

   logic                           ram_wr_en, ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [RW-1:0]                  ram_rd_data;
   logic [mns_pkg::FREQ_W-1:0]     rd_pitch;
   logic [mns_pkg::LEN_W-1:0]      rd_len;

   logic [XW-1:0]                  cur_x, nxt_x, idx_x;
   logic [CW:0]                    nxt;
   logic                           wrap;
   logic [mns_pkg::LEN_W-1:0]      timer_nxt;
   logic [mns_pkg::DUR_W+2:0]      len_num;
   logic [mns_pkg::PWM_W-1:0]      new_reload;
   logic [mns_pkg::PWM_W+1:0]      reload_x3;
   logic                           req_take, cfg_write;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && (state_ff == ST_IDLE);

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = paddr[2] ? {{(mns_pkg::APB_DW-1){1'b0}}, loop_ff}
                               : {{(mns_pkg::APB_DW-CW){1'b0}}, count_ff};

   assign rd_pitch = ram_rd_data[RW-1:mns_pkg::LEN_W];
   assign rd_len   = ram_rd_data[mns_pkg::LEN_W-1:0];

   assign cur_x = XW'(cur_ff);
   assign idx_x = XW'(req_if.note_index);
   assign nxt   = {1'b0, cur_ff} + {{CW{1'b0}}, 1'b1};
   assign wrap  = (nxt >= {1'b0, count_ff}) || ((XW+1)'(nxt) >= DEPTH_X);
   assign nxt_x = XW'(nxt[CW-1:0]);
   assign timer_nxt = timer_ff + {{(mns_pkg::LEN_W-1){1'b0}}, 1'b1};
   assign len_num   = {1'b0, req_if.note_duration, 2'b00}
                      + {3'b000, req_if.note_duration} + (mns_pkg::DUR_W+3)'(2);

   assign trial    = {div_rem_ff, div_q_ff[mns_pkg::DIV_W-1]};
   assign trial_ge = (trial >= {1'b0, div_d_ff});

   assign new_reload = div_q_ff[mns_pkg::PWM_W-1:0] - {{(mns_pkg::PWM_W-1){1'b0}}, 1'b1};
   assign reload_x3  = {2'b00, new_reload} + {1'b0, new_reload, 1'b0};

   always_comb begin
      state_in      = state_ff;
      playing_in    = playing_ff;
      cur_in        = cur_ff;
      timer_in      = timer_ff;
      reload_in     = reload_ff;
      compare_in    = compare_ff;
      upd_in        = upd_ff;
      ret_step_in   = ret_step_ff;
      div_len_in    = div_len_ff;
      hold_pitch_in = hold_pitch_ff;
      hold_addr_in  = hold_addr_ff;
      div_q_in      = div_q_ff;
      div_rem_in    = div_rem_ff;
      div_d_in      = div_d_ff;
      div_cnt_in    = div_cnt_ff;
      div_start     = 1'b0;
      div_dividend  = mns_pkg::TONE_CLOCK;
      div_divisor   = mns_pkg::LEN_DIVISOR;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cur_x[AW-1:0];
      out_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               upd_in        = 1'b0;
               hold_pitch_in = req_if.note_frequency;
               hold_addr_in  = idx_x[AW-1:0];
               state_in      = ST_RESP;
               case (req_if.func)
                  mns_pkg::FUNC_LOAD: begin
                     if ((XW+1)'(req_if.note_index) < DEPTH_X) begin
                        div_len_in   = 1'b1;
                        div_start    = 1'b1;
                        div_dividend = mns_pkg::DIV_W'(len_num);
                        div_divisor  = mns_pkg::LEN_DIVISOR;
                        state_in     = ST_DIV;
                     end
                  end
                  mns_pkg::FUNC_START: begin
                     if (count_ff != '0) begin
                        cur_in     = '0;
                        timer_in   = '0;
                        playing_in = 1'b1;
                     end
                  end
                  mns_pkg::FUNC_STOP: begin
                     playing_in = 1'b0;
                     compare_in = '0;
                     upd_in     = 1'b1;
                  end
                  mns_pkg::FUNC_TICK: begin
                     if (playing_ff) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_NOTE;
                     end
                  end
                  mns_pkg::FUNC_TONE: begin
                     upd_in = 1'b1;
                     if (req_if.tone_frequency == '0) begin
                        compare_in = '0;
                     end else begin
                        div_len_in   = 1'b0;
                        ret_step_in  = 1'b0;
                        div_start    = 1'b1;
                        div_dividend = mns_pkg::TONE_CLOCK;
                        div_divisor  = mns_pkg::tone_adjust(req_if.tone_frequency);
                        state_in     = ST_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_NOTE: begin
            state_in = ST_STEP;
            if (timer_ff == '0) begin
               upd_in = 1'b1;
               if (rd_pitch == '0) begin
                  compare_in = '0;
               end else begin
                  div_len_in   = 1'b0;
                  ret_step_in  = 1'b1;
                  div_start    = 1'b1;
                  div_dividend = mns_pkg::TONE_CLOCK;
                  div_divisor  = mns_pkg::tone_adjust(rd_pitch);
                  state_in     = ST_DIV;
               end
            end
         end
         ST_STEP: begin
            state_in = ST_RESP;
            if (timer_nxt >= rd_len) begin
               timer_in = '0;
               if (wrap && !loop_ff) begin
                  playing_in = 1'b0;
                  compare_in = '0;
                  upd_in     = 1'b1;
               end else begin
                  upd_in    = 1'b1;
                  ram_rd_en = 1'b1;
                  state_in  = ST_NEXT;
                  if (wrap) begin
                     cur_in      = '0;
                     ram_rd_addr = '0;
                  end else begin
                     cur_in      = nxt[CW-1:0];
                     ram_rd_addr = nxt_x[AW-1:0];
                  end
               end
            end else begin
               timer_in = timer_nxt;
            end
         end
         ST_NEXT: begin
            if (rd_pitch == '0) begin
               compare_in = '0;
               state_in   = ST_RESP;
            end else begin
               div_len_in   = 1'b0;
               ret_step_in  = 1'b0;
               div_start    = 1'b1;
               div_dividend = mns_pkg::TONE_CLOCK;
               div_divisor  = mns_pkg::tone_adjust(rd_pitch);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (trial_ge) begin
               div_rem_in = mns_pkg::ADJ_W'(trial - {1'b0, div_d_ff});
               div_q_in   = {div_q_ff[mns_pkg::DIV_W-2:0], 1'b1};
            end else begin
               div_rem_in = trial[mns_pkg::ADJ_W-1:0];
               div_q_in   = {div_q_ff[mns_pkg::DIV_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + {{(mns_pkg::STEP_W-1){1'b0}}, 1'b1};
            if (div_cnt_ff == mns_pkg::STEP_W'(mns_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (div_len_ff) begin
               ram_wr_en = 1'b1;
               state_in  = ST_RESP;
            end else begin
               reload_in  = new_reload;
               compare_in = reload_x3[mns_pkg::PWM_W+1:2];
               state_in   = ret_step_ff ? ST_STEP : ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               out_load     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (div_start) begin
         div_q_in   = div_dividend;
         div_rem_in = '0;
         div_d_in   = div_divisor;
         div_cnt_in = '0;
      end
   end

   assign count_in = (cfg_write && !paddr[2]) ? pwdata[CW-1:0] : count_ff;
   assign loop_in  = (cfg_write &&  paddr[2]) ? pwdata[0] : loop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         cur_ff       <= '0;
         timer_ff     <= '0;
         reload_ff    <= mns_pkg::RELOAD_RESET;
         compare_ff   <= '0;
         count_ff     <= '0;
         loop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         cur_ff       <= cur_in;
         timer_ff     <= timer_in;
         reload_ff    <= reload_in;
         compare_ff   <= compare_in;
         count_ff     <= count_in;
         loop_ff      <= loop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_ff        <= upd_in;
      ret_step_ff   <= ret_step_in;
      div_len_ff    <= div_len_in;
      hold_pitch_ff <= hold_pitch_in;
      hold_addr_ff  <= hold_addr_in;
      div_q_ff      <= div_q_in;
      div_rem_ff    <= div_rem_in;
      div_d_ff      <= div_d_in;
      div_cnt_ff    <= div_cnt_in;
      if (out_load) begin
         out_reload_ff  <= reload_ff;
         out_compare_ff <= compare_ff;
         out_upd_ff     <= upd_ff;
         out_playing_ff <= playing_ff;
         out_pos_ff     <= cur_ff[mns_pkg::INDEX_W-1:0];
      end
   end

   mns_ram #(
      .WIDTH (RW),
      .DEPTH (NOTE_DEPTH)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (hold_addr_ff),
      .wr_data ({hold_pitch_ff, div_q_ff[mns_pkg::LEN_W-1:0]}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.period_reload     = out_reload_ff;
   assign rsp_if.compare_value     = out_compare_ff;
   assign rsp_if.registers_updated = out_upd_ff;
   assign rsp_if.melody_playing    = out_playing_ff;
   assign rsp_if.note_position     = out_pos_ff;

endmodule

// ----- hw/rtl/mns_ram.sv -----
// ----------------------------------------------------------------------------
// mns_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module mns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- bench/mns_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// mns_tb_pkg
// Register map and spare command codes shared by the sequencer bench files.
// ----------------------------------------------------------------------------
package mns_tb_pkg;

   localparam logic [mns_pkg::APB_AW-1:0] REG_NOTE_COUNT  = 'd0;
   localparam logic [mns_pkg::APB_AW-1:0] REG_LOOP_ENABLE = 'd4;

   // first of the command codes that the sequencer leaves unused
   localparam logic [mns_pkg::FUNC_W-1:0] FUNC_SPARE = 'd5;

endpackage

// ----- bench/mns_tone_checker.sv -----
// ----------------------------------------------------------------------------
// mns_tone_checker
// Watches the request, response and register ports of the melody sequencer,
// keeps its own copy of the note store, playback state and pwm settings, and
// compares every response word with the status it predicts, oldest first.
// ----------------------------------------------------------------------------
module mns_tone_checker (
   input  logic                       clock,
   input  logic                       reset,
   mns_req_if                         req,
   mns_rsp_if                         rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [mns_pkg::APB_AW-1:0] paddr,
   input  logic [mns_pkg::APB_DW-1:0] pwdata,
   output int                         failures,
   output int                         pending
);

   localparam int DEPTH = mns_pkg::NOTE_DEPTH_DEF;

   typedef struct packed {
      logic [mns_pkg::PWM_W-1:0]   reload;
      logic [mns_pkg::PWM_W-1:0]   compare;
      logic                        updated;
      logic                        playing;
      logic [mns_pkg::INDEX_W-1:0] position;
   } tone_status_type;

   logic [mns_pkg::FREQ_W-1:0]  pitch_mem [DEPTH];
   logic [mns_pkg::LEN_W-1:0]   length_mem [DEPTH];
   int unsigned                 cur_note;
   logic [mns_pkg::LEN_W-1:0]   frames;
   logic                        playing;
   logic [mns_pkg::PWM_W-1:0]   reload;
   logic [mns_pkg::PWM_W-1:0]   compare;
   logic [mns_pkg::COUNT_W-1:0] note_count;
   logic                        loop_on;
   tone_status_type             status_q [$];
   tone_status_type             want;
   int                          fail_count;

   function automatic void retune(input logic [mns_pkg::FREQ_W-1:0] f);
      int unsigned fv;
      int unsigned scaled;
      int unsigned r;
      fv = f;
      if (fv == 0) begin
         compare = '0;
         return;
      end
      scaled = (fv < 1000) ? fv * 4 : fv * 5;
      if (scaled > 10000) scaled = 10000;
      if (scaled < 1200) scaled = 1200;
      r = 1000000 / scaled - 1;
      reload = r[mns_pkg::PWM_W-1:0];
      compare = mns_pkg::PWM_W'((r * 3) / 4);
   endfunction

   function automatic tone_status_type predict_status(
         input logic [mns_pkg::FUNC_W-1:0]  op,
         input logic [mns_pkg::INDEX_W-1:0] idx,
         input logic [mns_pkg::FREQ_W-1:0]  nf,
         input logic [mns_pkg::DUR_W-1:0]   nd,
         input logic [mns_pkg::FREQ_W-1:0]  tf);
      tone_status_type st;
      logic            upd;
      logic            halted;
      int unsigned     pos;
      int unsigned     active;
      upd = 1'b0;
      halted = 1'b0;
      case (op)
         mns_pkg::FUNC_LOAD: begin
            pitch_mem[idx] = nf;
            length_mem[idx] = mns_pkg::LEN_W'((nd * 5 + 2) / 3);
         end
         mns_pkg::FUNC_START: begin
            if (note_count != '0) begin
               cur_note = 0;
               frames = '0;
               playing = 1'b1;
            end
         end
         mns_pkg::FUNC_STOP: begin
            playing = 1'b0;
            compare = '0;
            upd = 1'b1;
         end
         mns_pkg::FUNC_TICK: begin
            if (playing) begin
               pos = (cur_note < DEPTH) ? cur_note : 0;
               cur_note = pos;
               if (frames == '0) begin
                  retune(pitch_mem[pos]);
                  upd = 1'b1;
               end
               frames = frames + 1'b1;
               if (frames >= length_mem[pos]) begin
                  frames = '0;
                  pos++;
                  active = (note_count < DEPTH) ? note_count : DEPTH;
                  if (pos >= active) begin
                     if (loop_on) begin
                        pos = 0;
                     end else begin
                        playing = 1'b0;
                        compare = '0;
                        upd = 1'b1;
                        halted = 1'b1;
                     end
                  end
                  if (!halted) begin
                     cur_note = pos;
                     retune(pitch_mem[pos]);
                     upd = 1'b1;
                  end
               end
            end
         end
         mns_pkg::FUNC_TONE: begin
            retune(tf);
            upd = 1'b1;
         end
         default: ;
      endcase
      st.reload = reload;
      st.compare = compare;
      st.updated = upd;
      st.playing = playing;
      st.position = mns_pkg::INDEX_W'(cur_note);
      return st;
   endfunction

   function automatic int field_diff(input string name, input int unsigned exp_v,
                                     input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cur_note = 0;
         frames = '0;
         playing = 1'b0;
         reload = mns_pkg::RELOAD_RESET;
         compare = '0;
         note_count = '0;
         loop_on = 1'b0;
         status_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == mns_tb_pkg::REG_NOTE_COUNT) begin
               note_count = pwdata[mns_pkg::COUNT_W-1:0];
            end else if (paddr == mns_tb_pkg::REG_LOOP_ENABLE) begin
               loop_on = pwdata[0];
            end
         end
         if (req.valid && req.ready) begin
            status_q.push_back(predict_status(req.func, req.note_index, req.note_frequency,
                                              req.note_duration, req.tone_frequency));
         end
         if (rsp.valid && rsp.ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: response word with nothing expected, reload %0d compare %0d",
                        $time, rsp.period_reload, rsp.compare_value);
               fail_count++;
            end else begin
               want = status_q.pop_front();
               fail_count += field_diff("period_reload", want.reload, rsp.period_reload);
               fail_count += field_diff("compare_value", want.compare, rsp.compare_value);
               fail_count += field_diff("registers_updated", want.updated,
                                        rsp.registers_updated);
               fail_count += field_diff("melody_playing", want.playing, rsp.melody_playing);
               fail_count += field_diff("note_position", want.position, rsp.note_position);
            end
         end
      end
      failures <= fail_count;
      pending <= status_q.size();
   end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the melody sequencer with note loads, playback commands, ticks and
// direct tones under random backpressure, reprograms note count and looping
// between phases, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;

   localparam int IDLE_LIMIT  = 5000;
   localparam int WORD_TARGET = 1450;
   localparam int DEPTH       = mns_pkg::NOTE_DEPTH_DEF;

   logic                       clock;
   logic                       reset;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [mns_pkg::APB_AW-1:0] paddr;
   logic [mns_pkg::APB_DW-1:0] pwdata;
   logic [mns_pkg::APB_DW-1:0] prdata;
   logic                       pready;
   int                         failures;
   int                         pending;
   int                         words_sent;
   int                         loads_sent;
   int                         ticks_sent;
   int                         tones_sent;
   int                         csr_writes;
   int                         melodies;
   logic                       no_gaps;

   mns_req_if req_if ();
   mns_rsp_if rsp_if ();

   melody_note_sequencer_pwm u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mns_tone_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .pready   (pready),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [mns_pkg::FREQ_W-1:0] rand_pitch();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r < 4) return mns_pkg::FREQ_W'($urandom_range(1, 999));
      if (r < 7) return mns_pkg::FREQ_W'($urandom_range(1000, 2100));
      return mns_pkg::FREQ_W'($urandom);
   endfunction

   function automatic logic [mns_pkg::DUR_W-1:0] rand_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return mns_pkg::DUR_W'($urandom_range(0, 3));
      if (r < 17) return mns_pkg::DUR_W'($urandom_range(4, 12));
      if (r < 19) return mns_pkg::DUR_W'($urandom_range(13, 200));
      return mns_pkg::DUR_W'($urandom);
   endfunction

   task automatic send_word(input logic [mns_pkg::FUNC_W-1:0]  op,
                            input logic [mns_pkg::INDEX_W-1:0] idx,
                            input logic [mns_pkg::FREQ_W-1:0]  nf,
                            input logic [mns_pkg::DUR_W-1:0]   nd,
                            input logic [mns_pkg::FREQ_W-1:0]  tf);
      int gap;
      req_if.valid <= 1'b1;
      req_if.func <= op;
      req_if.note_index <= idx;
      req_if.note_frequency <= nf;
      req_if.note_duration <= nd;
      req_if.tone_frequency <= tf;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
      if (op == mns_pkg::FUNC_LOAD) loads_sent++;
      else if (op == mns_pkg::FUNC_TICK) ticks_sent++;
      else if (op == mns_pkg::FUNC_TONE) tones_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_cmd(input logic [mns_pkg::FUNC_W-1:0] op);
      send_word(op, mns_pkg::INDEX_W'($urandom), mns_pkg::FREQ_W'($urandom),
                mns_pkg::DUR_W'($urandom), mns_pkg::FREQ_W'($urandom));
   endtask

   task automatic send_tone(input logic [mns_pkg::FREQ_W-1:0] f);
      send_word(mns_pkg::FUNC_TONE, mns_pkg::INDEX_W'($urandom), mns_pkg::FREQ_W'($urandom),
                mns_pkg::DUR_W'($urandom), f);
   endtask

   task automatic send_load(input logic [mns_pkg::INDEX_W-1:0] idx,
                            input logic [mns_pkg::FREQ_W-1:0]  f,
                            input logic [mns_pkg::DUR_W-1:0]   d);
      send_word(mns_pkg::FUNC_LOAD, idx, f, d, mns_pkg::FREQ_W'($urandom));
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mns_pkg::APB_AW-1:0] addr,
                            input logic [mns_pkg::APB_DW-1:0] data);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      csr_writes++;
   endtask

   task automatic set_melody(input int count, input int loop_bit);
      csr_write(mns_tb_pkg::REG_NOTE_COUNT, mns_pkg::APB_DW'(count));
      csr_write(mns_tb_pkg::REG_LOOP_ENABLE, mns_pkg::APB_DW'(loop_bit));
      melodies++;
   endtask

   // response side: random backpressure with a periodic long hold
   initial begin
      int   rounds;
      int   r;
      int   span;
      logic level;
      rounds = 0;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         rounds++;
         r = $urandom_range(0, 99);
         if (rounds % 700 == 150) begin
            level = 1'b0;
            span = $urandom_range(300, 500);
         end else if (r < 60) begin
            level = 1'b1;
            span = $urandom_range(1, 12);
         end else if (r < 65) begin
            level = 1'b1;
            span = $urandom_range(40, 150);
         end else if (r < 92) begin
            level = 1'b0;
            span = $urandom_range(1, 3);
         end else begin
            level = 1'b0;
            span = $urandom_range(5, 40);
         end
         rsp_if.ready <= level;
         repeat (span) @(posedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog, %0d cycles with no word moving", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [mns_pkg::FREQ_W-1:0] tone_edges [7];
      logic [mns_pkg::DUR_W-1:0]  dur;
      int                         walk_ticks;
      int                         count;
      int                         body;
      int                         r;
      tone_edges = '{16'd0, 16'd1, 16'd300, 16'd999, 16'd1000, 16'd2000, 16'hFFFF};
      no_gaps = 1'b0;
      words_sent = 0;
      loads_sent = 0;
      ticks_sent = 0;
      tones_sent = 0;
      csr_writes = 0;
      melodies = 0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.func <= mns_pkg::FUNC_LOAD;
      req_if.note_index <= '0;
      req_if.note_frequency <= '0;
      req_if.note_duration <= '0;
      req_if.tone_frequency <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle corner cases
      send_cmd(mns_pkg::FUNC_TICK);
      send_cmd(mns_pkg::FUNC_START);
      send_cmd(mns_pkg::FUNC_STOP);
      for (int c = 0; c < 3; c++) send_cmd(mns_pkg::FUNC_W'(mns_tb_pkg::FUNC_SPARE + c));
      foreach (tone_edges[i]) send_tone(tone_edges[i]);

      // short melody: rest with zero length, top pitch, low pitch
      send_load('0, '0, '0);
      send_load(mns_pkg::INDEX_W'(1), 16'hFFFF, mns_pkg::DUR_W'(1));
      send_load(mns_pkg::INDEX_W'(2), mns_pkg::FREQ_W'(999), mns_pkg::DUR_W'(2));
      send_load({mns_pkg::INDEX_W{1'b1}}, mns_pkg::FREQ_W'(440), 16'hFFFF);
      set_melody(3, 0);
      send_cmd(mns_pkg::FUNC_START);
      repeat (8) send_cmd(mns_pkg::FUNC_TICK);

      // fill the whole store, then walk it through the wrap
      no_gaps = 1'b1;
      walk_ticks = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (i == DEPTH / 2) no_gaps = 1'b0;
         dur = ($urandom_range(0, 19) == 0) ? mns_pkg::DUR_W'(1) : '0;
         walk_ticks += (dur == '0) ? 1 : 2;
         send_load(mns_pkg::INDEX_W'(i), rand_pitch(), dur);
      end
      set_melody(DEPTH, 1);
      send_cmd(mns_pkg::FUNC_START);
      repeat (walk_ticks + 6) send_cmd(mns_pkg::FUNC_TICK);

      while (words_sent < WORD_TARGET) begin
         r = $urandom_range(0, 19);
         if (r < 13) count = $urandom_range(1, 8);
         else if (r < 17) count = $urandom_range(9, 64);
         else if (r < 19) count = $urandom_range(65, DEPTH);
         else count = (($urandom & 1) != 0) ? DEPTH : 1;
         set_melody(count, $urandom_range(0, 1));
         for (int i = 0; i < ((count < 8) ? count : 8); i++) begin
            send_load(mns_pkg::INDEX_W'(i), rand_pitch(), rand_length());
         end
         send_cmd(mns_pkg::FUNC_START);
         body = $urandom_range(15, 40);
         for (int i = 0; i < body; i++) begin
            // live count and loop change in mid melody
            if (i == body / 2 && $urandom_range(0, 2) == 0) begin
               set_melody($urandom_range(0, DEPTH), $urandom_range(0, 1));
            end
            r = $urandom_range(0, 99);
            if (r < 72) send_cmd(mns_pkg::FUNC_TICK);
            else if (r < 80) send_tone(rand_pitch());
            else if (r < 85) send_cmd(mns_pkg::FUNC_STOP);
            else if (r < 90) send_cmd(mns_pkg::FUNC_START);
            else if (r < 96) send_load(mns_pkg::INDEX_W'($urandom), rand_pitch(),
                                       rand_length());
            else send_cmd(mns_pkg::FUNC_W'($urandom_range(mns_tb_pkg::FUNC_SPARE,
                                                          (1 << mns_pkg::FUNC_W) - 1)));
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      $display("covered %0d request words: %0d note loads, %0d ticks, %0d direct tones",
               words_sent, loads_sent, ticks_sent, tones_sent);
      $display("%0d register writes over %0d melody setups, incl. a full store walk with wrap",
               csr_writes, melodies);
      if (failures == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
